>>> design/mcoc_pkg.sv
package mcoc_pkg;

  localparam int unsigned DimW    = 15;
  localparam int unsigned BppW    = 5;
  localparam int unsigned CntW    = 5;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned SizeW   = 33;
  localparam int unsigned ShiftW  = 3;
  localparam int unsigned MaskW   = 4;
  localparam int unsigned MulW    = 2 * DimW;

  localparam logic [DimW-1:0]  MaxDim    = DimW'(16384);
  localparam logic [CntW-1:0]  MaxLevels = CntW'(16);
  localparam logic [SizeW-1:0] SizeMax   = {SizeW{1'b1}};

  // Smallest alignment mask when the pixel size is at most four bytes.
  localparam logic [MaskW-1:0] MinAlignMask = MaskW'(3);

  // One classified request as the back part consumes it.
  typedef struct packed {
    logic              err;
    logic              is3;
    logic [ShiftW-1:0] shift;
    logic [MaskW-1:0]  align_mask;
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [CntW-1:0]   count;
  } cmd_t;

endpackage

>>> design/mip_chain_offset_calculator.sv
// A valid request gives its results in level order, one level per cycle while
// the output is not stalled; an invalid request gives a single error result.
// The back unit works a request as a load, a first multiply and one emit per
// level, and passes an error result straight on from the queue.
// A two-entry request queue sits between the classifier and the level walker.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
module mip_chain_offset_calculator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mcoc_pkg::BppW-1:0]  bytes_per_pixel_i,
  input  logic [mcoc_pkg::DimW-1:0]  base_width_i,
  input  logic [mcoc_pkg::DimW-1:0]  base_height_i,
  input  logic [mcoc_pkg::CntW-1:0]  level_count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mcoc_pkg::IdxW-1:0]  level_index_o,
  output logic [mcoc_pkg::SizeW-1:0] level_offset_o,
  output logic [mcoc_pkg::SizeW-1:0] total_size_o,
  output logic                       error_flag_o,
  output logic                       last_o
);
  import mcoc_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  mcoc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .bytes_per_pixel_i (bytes_per_pixel_i),
    .base_width_i      (base_width_i),
    .base_height_i     (base_height_i),
    .level_count_i     (level_count_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  mcoc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_index_o  (level_index_o),
    .level_offset_o (level_offset_o),
    .total_size_o   (total_size_o),
    .error_flag_o   (error_flag_o),
    .last_o         (last_o)
  );

endmodule

>>> design/mcoc_front.sv
module mcoc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [mcoc_pkg::BppW-1:0] bytes_per_pixel_i,
  input  logic [mcoc_pkg::DimW-1:0] base_width_i,
  input  logic [mcoc_pkg::DimW-1:0] base_height_i,
  input  logic [mcoc_pkg::CntW-1:0] level_count_i,
  output logic                      cmd_valid_o,
  output mcoc_pkg::cmd_t            cmd_o,
  input  logic                      cmd_pop_i
);
  import mcoc_pkg::*;

  cmd_t       cmd_in;
  cmd_t       queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  logic       pop;
  logic       bpp_ok;

  always_comb begin
    cmd_in = '0;
    bpp_ok = 1'b1;
    unique case (bytes_per_pixel_i)
      BppW'(1): begin
        cmd_in.shift = ShiftW'(0);
      end
      BppW'(2): begin
        cmd_in.shift = ShiftW'(1);
      end
      BppW'(3): begin
        cmd_in.is3 = 1'b1;
      end
      BppW'(4): begin
        cmd_in.shift = ShiftW'(2);
      end
      BppW'(8): begin
        cmd_in.shift = ShiftW'(3);
      end
      BppW'(16): begin
        cmd_in.shift = ShiftW'(4);
      end
      default: begin
        bpp_ok = 1'b0;
      end
    endcase
    cmd_in.err = !bpp_ok || (level_count_i == '0);
    cmd_in.align_mask = (cmd_in.shift > ShiftW'(2))
                        ? MaskW'((1 << cmd_in.shift) - 1) : MinAlignMask;
    cmd_in.width  = (base_width_i > MaxDim) ? MaxDim : base_width_i;
    cmd_in.height = (base_height_i > MaxDim) ? MaxDim : base_height_i;
    cmd_in.count  = (level_count_i > MaxLevels) ? MaxLevels : level_count_i;
  end

  assign in_stall_o  = fill_q[1];
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("command queue fill count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0 || fill_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("command queue pointers disagree with fill count");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0) |=> (fill_q != 2'd3))
    else $error("command queue underflow");
`endif

endmodule

>>> design/mcoc_back.sv
module mcoc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  mcoc_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mcoc_pkg::IdxW-1:0]  level_index_o,
  output logic [mcoc_pkg::SizeW-1:0] level_offset_o,
  output logic [mcoc_pkg::SizeW-1:0] total_size_o,
  output logic                       error_flag_o,
  output logic                       last_o
);
  import mcoc_pkg::*;

  cmd_t             cmd_q;
  logic             busy_q, busy_d;
  logic [DimW-1:0]  dim_w_q, dim_w_d;
  logic [DimW-1:0]  dim_h_q, dim_h_d;
  logic [CntW-1:0]  mul_left_q, mul_left_d;
  logic [SizeW-1:0] prod_q;
  logic             prod_vld_q, prod_vld_d;
  logic [CntW-1:0]  emit_idx_q, emit_idx_d;
  logic [SizeW-1:0] run_q, run_d;

  logic             out_vld_q, out_vld_d;
  logic [IdxW-1:0]  out_idx_q;
  logic [SizeW-1:0] out_off_q;
  logic [SizeW-1:0] out_tot_q;
  logic             out_err_q;
  logic             out_last_q;

  logic             out_free;
  logic             load;
  logic             err_fire;
  logic             emit_fire;
  logic             mul_fire;
  logic             emit_last;
  logic [MaskW-1:0] pad;
  logic [SizeW:0]   off_sum;
  logic [SizeW-1:0] off;
  logic [SizeW:0]   run_sum;
  logic [SizeW-1:0] run_new;
  logic [MulW-1:0]  mul;
  logic [SizeW:0]   scaled;

  assign out_free  = !out_vld_q || !out_stall_i;
  assign load      = !busy_q && cmd_valid_i && !cmd_i.err;
  assign err_fire  = !busy_q && cmd_valid_i && cmd_i.err && out_free;
  assign cmd_pop_o = load || err_fire;
  assign emit_fire = busy_q && prod_vld_q && out_free;
  assign mul_fire  = busy_q && (mul_left_q != '0) && (!prod_vld_q || emit_fire);
  assign emit_last = (emit_idx_q + CntW'(1)) == cmd_q.count;

  // Three-byte pixels keep the running size a multiple of three (every level
  // size is, and the total never reaches saturation), so the padding up to a
  // multiple of twelve follows from the two low bits alone.
  always_comb begin
    if (cmd_q.is3) begin
      pad = MaskW'(run_q[1:0]) * MaskW'(3);
    end else begin
      pad = (MaskW'(0) - run_q[MaskW-1:0]) & cmd_q.align_mask;
    end
    off_sum = {1'b0, run_q} + (SizeW+1)'(pad);
    off     = off_sum[SizeW] ? SizeMax : off_sum[SizeW-1:0];
    run_sum = {1'b0, off} + {1'b0, prod_q};
    run_new = run_sum[SizeW] ? SizeMax : run_sum[SizeW-1:0];
  end

  always_comb begin
    mul = MulW'(dim_w_q) * MulW'(dim_h_q);
    if (cmd_q.is3) begin
      scaled = ((SizeW+1)'(mul) << 1) + (SizeW+1)'(mul);
    end else begin
      scaled = (SizeW+1)'(mul) << cmd_q.shift;
    end
  end

  always_comb begin
    busy_d     = busy_q;
    dim_w_d    = dim_w_q;
    dim_h_d    = dim_h_q;
    mul_left_d = mul_left_q;
    prod_vld_d = prod_vld_q;
    emit_idx_d = emit_idx_q;
    run_d      = run_q;
    if (load) begin
      busy_d     = 1'b1;
      dim_w_d    = cmd_i.width;
      dim_h_d    = cmd_i.height;
      mul_left_d = cmd_i.count;
      prod_vld_d = 1'b0;
      emit_idx_d = '0;
      run_d      = '0;
    end else begin
      if (emit_fire) begin
        prod_vld_d = 1'b0;
        emit_idx_d = emit_idx_q + CntW'(1);
        run_d      = run_new;
        if (emit_last) begin
          busy_d = 1'b0;
        end
      end
      if (mul_fire) begin
        prod_vld_d = 1'b1;
        mul_left_d = mul_left_q - CntW'(1);
        dim_w_d    = (dim_w_q[DimW-1:1] == '0) ? DimW'(1) : (dim_w_q >> 1);
        dim_h_d    = (dim_h_q[DimW-1:1] == '0) ? DimW'(1) : (dim_h_q >> 1);
      end
    end
  end

  assign out_vld_d = err_fire || emit_fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      mul_left_q <= '0;
      prod_vld_q <= 1'b0;
      emit_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      mul_left_q <= mul_left_d;
      prod_vld_q <= prod_vld_d;
      emit_idx_q <= emit_idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dim_w_q <= dim_w_d;
    dim_h_q <= dim_h_d;
    run_q   <= run_d;
    if (load) begin
      cmd_q <= cmd_i;
    end
    if (mul_fire) begin
      prod_q <= scaled[SizeW-1:0];
    end
    if (err_fire) begin
      out_idx_q  <= '0;
      out_off_q  <= '0;
      out_tot_q  <= '0;
      out_err_q  <= 1'b1;
      out_last_q <= 1'b1;
    end else if (emit_fire) begin
      out_idx_q  <= emit_idx_q[IdxW-1:0];
      out_off_q  <= off;
      out_tot_q  <= emit_last ? run_new : '0;
      out_err_q  <= 1'b0;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign level_index_o  = out_idx_q;
  assign level_offset_o = out_off_q;
  assign total_size_o   = out_tot_q;
  assign error_flag_o   = out_err_q;
  assign last_o         = out_last_q;

`ifndef SYNTHESIS
  a_prod_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> busy_q)
    else $error("product held while no request is active");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (emit_idx_q < cmd_q.count))
    else $error("level index ran past the level count");
  a_mul_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((CntW+1)'(emit_idx_q) + (CntW+1)'(mul_left_q)
                + (CntW+1)'(prod_vld_q) == (CntW+1)'(cmd_q.count)))
    else $error("multiplier and emit counters out of step");
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_err_q) |-> (out_last_q && out_off_q == '0 && out_tot_q == '0))
    else $error("error result carries nonzero fields");
`endif

endmodule
